// ----- hw/rtl/cbrm_pkg.sv -----
// Shared types, constants and helper functions for the cartridge bank RAM mapper.
// Used by cartridge_bank_ram_mapper and the testbench; depends on nothing else.

package cbrm_pkg;

    localparam int RAM_WIDTH = 8;
    localparam int RAM_DEPTH = 2048;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam int BUS_AW    = 16;
    localparam int MAP_AW    = 13;
    localparam int ROM_AW    = 14;
    localparam int SEL_W     = 3;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_16K    = 2'd0,
        MODE_8K     = 2'd1,
        MODE_12K    = 2'd2,
        MODE_UNUSED = 2'd3
    } t_rom_mode;

    // Lower window select value that maps the RAM instead of a ROM bank.
    localparam logic [SEL_W-1:0] SEL_RAM = 3'd7;

    // Bank that holds the fixed top 2 KiB of the ROM, per size mode.
    localparam logic [SEL_W-1:0] TOP_BANK_16K = 3'd7;
    localparam logic [SEL_W-1:0] TOP_BANK_8K  = 3'd3;
    localparam logic [SEL_W-1:0] TOP_BANK_12K = 3'd5;

    // Hotspot groups, as address bits above the slot index.
    localparam logic [9:0]  HOT_LOWER = 10'h3FC;  // 0x1FE0-0x1FE7
    localparam logic [10:0] HOT_UPPER = 11'h7FA;  // 0x1FE8-0x1FEB

    // The 12 KiB mode maps seven hotspots onto five banks.
    function automatic logic [SEL_W-1:0] bank_12k(input logic [2:0] slot);
        logic [SEL_W-1:0] bank;
        case (slot)
            3'd0:    bank = 3'd0;
            3'd1:    bank = 3'd1;
            3'd2:    bank = 3'd0;
            3'd3:    bank = 3'd1;
            3'd4:    bank = 3'd2;
            3'd5:    bank = 3'd3;
            3'd6:    bank = 3'd4;
            default: bank = SEL_RAM;
        endcase
        return bank;
    endfunction

    function automatic logic [SEL_W-1:0] top_bank(input t_rom_mode mode);
        logic [SEL_W-1:0] bank;
        case (mode)
            MODE_8K:  bank = TOP_BANK_8K;
            MODE_12K: bank = TOP_BANK_12K;
            default:  bank = TOP_BANK_16K;
        endcase
        return bank;
    endfunction

endpackage

// ----- hw/rtl/cartridge_bank_ram_mapper.sv -----
// Top level of the cartridge bank RAM mapper: hotspot decode, bank state and address map.
// Depends on cbrm_pkg and cbrm_ram (2 KiB cartridge RAM).
//
//  channel   | direction | beat carries
//  ----------+-----------+-------------------------------------------------------
//  s_axis    | in        | tuser: cmd; tdata: bus_address[15:0], bus_data[23:16]
//  m_axis    | out       | tuser: from_rom; tdata: result_data[7:0], rom_address[21:8]
//  cfg       | in        | wdata: rom_size_mode, written when we is high
//
// Each accepted beat has its result shown the next cycle; one beat per
// cycle is sustained while the output side keeps taking results.
// A beat reads or writes the RAM at most once, and never both.
// After reset the RAM is cleared one byte a cycle, all 2048 bytes, with input held off.
// A stalled result holds its slot; a new beat enters only as the slot drains.

module cartridge_bank_ram_mapper (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_wdata,     // rom_size_mode
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [cbrm_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // bus_address, bus_data
    input  logic                               i_s_axis_tuser,  // cmd
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [cbrm_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // result_data, rom_address, 0
    output logic                               o_m_axis_tuser   // from_rom
);

    localparam int AW = cbrm_pkg::RAM_AW;

    // Configuration and bank state.
    cbrm_pkg::t_rom_mode            r_mode;
    logic [cbrm_pkg::SEL_W-1:0]     r_sel, n_sel;
    logic [1:0]                     r_page, n_page;

    // RAM clearing sweep.
    logic                           r_clearing;
    logic [AW-1:0]                  r_clr_addr;

    // Result slot.
    logic                           r_valid;
    logic                           r_from_rom, n_from_rom;
    logic                           r_use_ram, n_use_ram;
    logic [7:0]                     r_data, n_data;
    logic [cbrm_pkg::ROM_AW-1:0]    r_rom_addr, n_rom_addr;

    logic                           accept;
    logic                           is_write;
    logic [cbrm_pkg::MAP_AW-1:0]    a;
    logic [7:0]                     d;
    logic                           in_low_w, in_low, in_up_w, in_up_r, in_top;
    logic [AW-1:0]                  low_addr, up_addr;
    logic                           acc_wr, acc_rd;
    logic [AW-1:0]                  acc_addr;

    logic                           ram_we, ram_re;
    logic [AW-1:0]                  ram_waddr;
    logic [7:0]                     ram_wdata, ram_rdata;
    logic [7:0]                     out_data;

    assign is_write = (cbrm_pkg::t_cmd'(i_s_axis_tuser) == cbrm_pkg::CMD_WRITE);
    assign a        = i_s_axis_tdata[cbrm_pkg::MAP_AW-1:0];
    assign d        = i_s_axis_tdata[cbrm_pkg::BUS_AW +: 8];

    assign o_s_axis_tready = !r_clearing && (!r_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Address regions of the 13-bit cartridge space.
    assign in_low_w = (a[12:10] == 3'b100);                  // 0x1000-0x13FF
    assign in_low   = (a[12:11] == 2'b10);                   // 0x1000-0x17FF
    assign in_up_w  = (a[12:8] == 5'h18);                    // 0x1800-0x18FF
    assign in_up_r  = (a[12:8] == 5'h19);                    // 0x1900-0x19FF
    assign in_top   = (a[12:11] == 2'b11) && (a[10] || a[9]); // 0x1A00-0x1FFF

    assign low_addr = {1'b0, a[9:0]};
    assign up_addr  = {1'b1, r_page, a[7:0]};

    // Hotspot addresses never fall inside the RAM or banked windows, so the access
    // itself can use the select and page values from before this beat.
    always_comb begin
        n_sel  = r_sel;
        n_page = r_page;
        if (a[12:2] == cbrm_pkg::HOT_UPPER) begin
            n_page = a[1:0];
        end
        if (a[12:3] == cbrm_pkg::HOT_LOWER) begin
            if (a[2:0] == 3'd7) begin
                n_sel = cbrm_pkg::SEL_RAM;
            end else begin
                case (r_mode)
                    cbrm_pkg::MODE_8K: begin
                        if (a[2]) begin
                            n_sel = {1'b0, a[1:0]};
                        end
                    end
                    cbrm_pkg::MODE_12K: n_sel = cbrm_pkg::bank_12k(a[2:0]);
                    default:            n_sel = a[2:0];
                endcase
            end
        end
    end

    always_comb begin
        acc_wr     = 1'b0;
        acc_rd     = 1'b0;
        acc_addr   = low_addr;
        n_from_rom = 1'b0;
        n_use_ram  = 1'b0;
        n_data     = d;
        n_rom_addr = '0;
        if (is_write) begin
            if (r_sel == cbrm_pkg::SEL_RAM && in_low_w) begin
                acc_wr = 1'b1;
            end else if (in_up_w) begin
                acc_wr   = 1'b1;
                acc_addr = up_addr;
            end
        end else if (in_low) begin
            if (r_sel != cbrm_pkg::SEL_RAM) begin
                n_from_rom = 1'b1;
                n_rom_addr = {r_sel, a[10:0]};
            end else if (in_low_w) begin
                // Reads of the lower quarter act as the RAM write port.
                acc_wr = 1'b1;
            end else begin
                acc_rd    = 1'b1;
                n_use_ram = 1'b1;
            end
        end else if (in_up_w) begin
            acc_wr   = 1'b1;
            acc_addr = up_addr;
        end else if (in_up_r) begin
            acc_rd    = 1'b1;
            n_use_ram = 1'b1;
            acc_addr  = up_addr;
        end else if (in_top) begin
            n_from_rom = 1'b1;
            n_rom_addr = {cbrm_pkg::top_bank(r_mode), a[10:0]};
        end
        if (n_from_rom) begin
            n_data = '0;
        end
    end

    assign ram_we    = r_clearing || (accept && acc_wr);
    assign ram_waddr = r_clearing ? r_clr_addr : acc_addr;
    assign ram_wdata = r_clearing ? 8'd0 : d;
    assign ram_re    = accept && acc_rd;

    cbrm_ram #(
        .WIDTH (cbrm_pkg::RAM_WIDTH),
        .DEPTH (cbrm_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (acc_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= cbrm_pkg::MODE_16K;
            r_sel      <= '0;
            r_page     <= '0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= cbrm_pkg::t_rom_mode'(i_cfg_wdata);
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept) begin
                r_sel   <= n_sel;
                r_page  <= n_page;
                r_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // The RAM read register only moves on an accepted beat, so it holds while stalled.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_from_rom <= n_from_rom;
            r_use_ram  <= n_use_ram;
            r_data     <= n_data;
            r_rom_addr <= n_rom_addr;
        end
    end

    assign out_data        = r_use_ram ? ram_rdata : r_data;
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tuser  = r_from_rom;
    assign o_m_axis_tdata  = {2'b00, r_rom_addr, out_data};

    a_rom_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[7:0] == 8'd0)
        else $error("ROM fetch result carries nonzero data");

    a_data_rom_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[21:8] == '0)
        else $error("data result carries a ROM address");

    a_one_ram_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_re && ram_we))
        else $error("RAM read and write issued in the same cycle");

    a_ram_read_not_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && acc_rd |=> r_use_ram && !r_from_rom)
        else $error("RAM read beat produced a ROM fetch");

endmodule

// ----- hw/rtl/cbrm_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; sized by the WIDTH and DEPTH parameters.

module cbrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for cartridge_bank_ram_mapper: bus accesses in, mapped results out.
// Depends on cbrm_pkg and the mapper RTL; it keeps its own model of banks, pages and RAM.

module tb_top;

    localparam logic [12:0] HOTSPOT_LOWER = 13'h1FE0;
    localparam logic [12:0] HOTSPOT_UPPER = 13'h1FE8;
    localparam logic [12:0] HOTSPOT_RAM   = 13'h1FE7;

    typedef struct packed {
        logic        from_rom;
        logic [7:0]  data;
        logic [13:0] rom_addr;
    } t_map_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [1:0]                       i_cfg_wdata = 2'd0;     // rom_size_mode
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    // bus_address[15:0], bus_data[23:16]
    logic [cbrm_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                             i_s_axis_tuser = 1'b0;  // cmd
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b1;
    // result_data[7:0], rom_address[21:8]
    logic [cbrm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                             o_m_axis_tuser;         // from_rom

    // Mapper state as the block should hold it.
    cbrm_pkg::t_rom_mode rom_mode_q;
    logic [2:0]          window_sel_q;
    logic [1:0]          ram_page_q;
    logic [7:0]          cart_ram_image [cbrm_pkg::RAM_DEPTH];

    t_map_result results_due [$];
    int          mismatch_count = 0;
    bit          idle_bursts = 1'b1;

    cartridge_bank_ram_mapper u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("cartridge_bank_ram_mapper regression: fail");
        $finish;
    end

    function automatic void clear_mapper_model();
        rom_mode_q   = cbrm_pkg::MODE_16K;
        window_sel_q = 3'd0;
        ram_page_q   = 2'd0;
        foreach (cart_ram_image[i]) cart_ram_image[i] = 8'h00;
    endfunction

    // Applies one bus access to the model and returns what the mapper must answer.
    function automatic t_map_result map_bus_access(cbrm_pkg::t_cmd cmd,
                                                   logic [15:0] bus_addr,
                                                   logic [7:0] bus_data);
        logic [12:0]  a;
        logic [10:0]  page_byte;
        logic [2:0]   slot;
        logic [2:0]   banks_12k [7];
        int unsigned  rom_top;
        t_map_result  r;
        banks_12k = '{3'd0, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4};
        a = bus_addr[12:0];
        // The upper page offset uses the page in effect before this access.
        page_byte = {1'b1, ram_page_q, a[7:0]};
        r = '{from_rom: 1'b0, data: bus_data, rom_addr: 14'd0};

        if (a >= HOTSPOT_UPPER && a <= HOTSPOT_UPPER + 13'd3) ram_page_q = a[1:0];
        if (a >= HOTSPOT_LOWER && a <= HOTSPOT_RAM) begin
            slot = a[2:0];
            if (a == HOTSPOT_RAM) begin
                window_sel_q = cbrm_pkg::SEL_RAM;
            end else begin
                case (rom_mode_q)
                    cbrm_pkg::MODE_8K: begin
                        if (slot >= 3'd4) window_sel_q = slot - 3'd4;
                    end
                    cbrm_pkg::MODE_12K: window_sel_q = banks_12k[slot];
                    default:            window_sel_q = slot;
                endcase
            end
        end

        case (rom_mode_q)
            cbrm_pkg::MODE_8K:  rom_top = 32'h2000;
            cbrm_pkg::MODE_12K: rom_top = 32'h3000;
            default:            rom_top = 32'h4000;
        endcase

        if (cmd == cbrm_pkg::CMD_WRITE) begin
            if (window_sel_q == cbrm_pkg::SEL_RAM && a >= 13'h1000 && a <= 13'h13FF)
                cart_ram_image[{1'b0, a[9:0]}] = bus_data;
            else if (a >= 13'h1800 && a <= 13'h18FF)
                cart_ram_image[page_byte] = bus_data;
        end else if (a >= 13'h1000 && a <= 13'h17FF) begin
            if (window_sel_q != cbrm_pkg::SEL_RAM) begin
                r.from_rom = 1'b1;
                r.rom_addr = {window_sel_q, a[10:0]};
            end else if (a <= 13'h13FF) begin
                // A read in the RAM write port stores the bus byte.
                cart_ram_image[{1'b0, a[9:0]}] = bus_data;
            end else begin
                r.data = cart_ram_image[{1'b0, a[9:0]}];
            end
        end else if (a >= 13'h1800 && a <= 13'h18FF) begin
            cart_ram_image[page_byte] = bus_data;
        end else if (a >= 13'h1900 && a <= 13'h19FF) begin
            r.data = cart_ram_image[page_byte];
        end else if (a >= 13'h1A00) begin
            r.from_rom = 1'b1;
            r.rom_addr = 14'(rom_top - 32'h800 + a[10:0]);
        end

        if (r.from_rom) r.data = 8'h00;
        return r;
    endfunction

    // Sends one access beat; the model is updated at the edge that accepts it.
    task automatic drive_access(input cbrm_pkg::t_cmd cmd, input logic [15:0] addr,
                                input logic [7:0] data);
        if (idle_bursts && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {data, addr};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        results_due.push_back(map_bus_access(cmd, addr, data));
    endtask

    task automatic wait_results_drained();
        int waited;
        waited = 0;
        i_s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_rom_mode(input cbrm_pkg::t_rom_mode mode);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rom_mode_q = mode;
    endtask

    function automatic logic [15:0] pick_bus_address();
        logic [12:0] a;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            // Favor the RAM hotspot so the RAM window stays open for a while.
            if ($urandom_range(0, 1) == 0) a = HOTSPOT_RAM;
            else a = 13'(HOTSPOT_LOWER + $urandom_range(0, 11));
        end else if (roll < 55) begin
            a = 13'(13'h1000 + $urandom_range(0, 13'h7FF));
            if ($urandom_range(0, 1) == 0) a[9:3] = '0;
        end else if (roll < 80) begin
            a = 13'(13'h1800 + $urandom_range(0, 13'h1FF));
            if ($urandom_range(0, 1) == 0) a[7:3] = '0;
        end else if (roll < 88) begin
            a = 13'(13'h1A00 + $urandom_range(0, 13'h5FF));
        end else begin
            a = 13'($urandom_range(0, 13'h1FFF));
        end
        return {3'($urandom_range(0, 7)), a};
    endfunction

    task automatic test_directed_map();
        set_rom_mode(cbrm_pkg::MODE_16K);
        drive_access(cbrm_pkg::CMD_READ,  16'h1400, 8'h00);   // bank 0 from reset
        drive_access(cbrm_pkg::CMD_READ,  16'h0000, 8'hFF);   // below the cartridge: echo
        drive_access(cbrm_pkg::CMD_WRITE, 16'hFFFF, 8'h00);   // upper bus bits are dropped
        drive_access(cbrm_pkg::CMD_READ,  16'hFFFF, 8'h77);
        drive_access(cbrm_pkg::CMD_READ,  16'hFFE7, 8'h00);   // select RAM
        drive_access(cbrm_pkg::CMD_READ,  16'h1400, 8'h12);   // cleared RAM reads zero
        drive_access(cbrm_pkg::CMD_READ,  16'h1000, 8'hA5);   // read in the write port stores
        drive_access(cbrm_pkg::CMD_READ,  16'h1400, 8'h00);
        drive_access(cbrm_pkg::CMD_WRITE, 16'h13FF, 8'h5A);
        drive_access(cbrm_pkg::CMD_READ,  16'h77FF, 8'h00);
        drive_access(cbrm_pkg::CMD_WRITE, 16'h1FEB, 8'h00);   // upper page 3
        drive_access(cbrm_pkg::CMD_READ,  16'h18FF, 8'h3C);
        drive_access(cbrm_pkg::CMD_READ,  16'h19FF, 8'h00);
        drive_access(cbrm_pkg::CMD_READ,  16'h1FE8, 8'h00);   // back to page 0
        drive_access(cbrm_pkg::CMD_READ,  16'h19FF, 8'h00);
        drive_access(cbrm_pkg::CMD_READ,  16'h1FE6, 8'h00);   // ROM bank 6 closes the RAM window
        drive_access(cbrm_pkg::CMD_WRITE, 16'h1000, 8'h99);   // no store with ROM selected
    endtask

    task automatic test_rom_modes();
        // Bank 6 chosen under 16 KiB survives the switch and points past an 8 KiB ROM.
        set_rom_mode(cbrm_pkg::MODE_8K);
        drive_access(cbrm_pkg::CMD_READ,  16'h17FF, 8'h00);
        drive_access(cbrm_pkg::CMD_READ,  16'h1FE0, 8'h00);   // ignored in 8 KiB mode
        drive_access(cbrm_pkg::CMD_READ,  16'h1000, 8'h00);
        drive_access(cbrm_pkg::CMD_WRITE, 16'h1FE5, 8'h11);
        drive_access(cbrm_pkg::CMD_READ,  16'h1A00, 8'h00);
        set_rom_mode(cbrm_pkg::MODE_12K);
        drive_access(cbrm_pkg::CMD_READ,  16'h1FE2, 8'h00);
        drive_access(cbrm_pkg::CMD_READ,  16'h1234, 8'h00);
        drive_access(cbrm_pkg::CMD_READ,  16'h1FE6, 8'h00);
        drive_access(cbrm_pkg::CMD_READ,  16'h1A00, 8'h00);
        set_rom_mode(cbrm_pkg::MODE_UNUSED);                  // behaves as 16 KiB
        drive_access(cbrm_pkg::CMD_READ,  16'h1FE5, 8'h00);
        drive_access(cbrm_pkg::CMD_READ,  16'h1FFF, 8'h00);
    endtask

    task automatic test_random_accesses();
        cbrm_pkg::t_rom_mode modes [6];
        modes = '{cbrm_pkg::MODE_16K, cbrm_pkg::MODE_8K, cbrm_pkg::MODE_12K,
                  cbrm_pkg::MODE_UNUSED, cbrm_pkg::MODE_12K, cbrm_pkg::MODE_16K};
        foreach (modes[m]) begin
            set_rom_mode(modes[m]);
            repeat (100) begin
                drive_access(cbrm_pkg::t_cmd'($urandom_range(0, 1)), pick_bus_address(),
                             8'($urandom_range(0, 255)));
                if ($urandom_range(0, 79) == 0) wait_results_drained();
            end
        end
    endtask

    // Full rate on both sides: no sender gaps and no receiver stalls.
    task automatic test_back_to_back();
        idle_bursts = 1'b0;
        set_rom_mode(cbrm_pkg::MODE_8K);
        repeat (100) begin
            drive_access(cbrm_pkg::t_cmd'($urandom_range(0, 1)), pick_bus_address(),
                         8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_bursts && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 30)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_map_result want;
        if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (results_due.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: result beat with none expected: tuser %b tdata %06h",
                             $realtime, o_m_axis_tuser, o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = results_due.pop_front();
                if (o_m_axis_tuser !== want.from_rom || o_m_axis_tdata[7:0] !== want.data ||
                    o_m_axis_tdata[21:8] !== want.rom_addr ||
                    o_m_axis_tdata[23:22] !== 2'b00) begin
                    if (mismatch_count < 10)
                        $display({"%0t: mismatch from_rom %b/%b result_data %02h/%02h ",
                                  "rom_address %04h/%04h pad %b (expected/actual)"},
                                 $realtime, want.from_rom, o_m_axis_tuser, want.data,
                                 o_m_axis_tdata[7:0], want.rom_addr, o_m_axis_tdata[21:8],
                                 o_m_axis_tdata[23:22]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        clear_mapper_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The RAM clear after reset holds off the input side.
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        test_directed_map();
        test_rom_modes();
        test_random_accesses();
        test_back_to_back();
        wait_results_drained();
        mismatch_count += results_due.size();
        if (mismatch_count == 0)
            $display("cartridge_bank_ram_mapper regression: pass");
        else
            $display("cartridge_bank_ram_mapper regression: fail");
        $finish;
    end

endmodule
